// ===== src/jcrt_pkg.sv =====
// shared types and constants of the joint cubic return trajectory core
// no dependencies
package jcrt_pkg;

    localparam logic [1:0] REG_TOTAL_TICKS     = 2'd0;
    localparam logic [1:0] REG_INV_TOTAL_TICKS = 2'd1;
    localparam logic [1:0] REG_INV_TOTAL_TIME  = 2'd2;

    localparam logic [15:0] TOTAL_TICKS_RST     = 16'd1000;
    localparam logic [31:0] INV_TOTAL_TICKS_RST = 32'd4294967;
    localparam logic [31:0] INV_TOTAL_TIME_RST  = 32'd65536;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic [15:0] total_ticks;
        logic [31:0] inv_total_ticks;
        logic [31:0] inv_total_time;
    } jcrt_cfg_t;

    typedef struct packed {
        logic [3:0]         joint;
        logic               done;
        logic [15:0]        tick;
        logic signed [31:0] start;
        logic signed [31:0] target;
    } jcrt_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -52'sh0_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/joint_cubic_return_trajectory_core.sv =====
// top level of the joint cubic return trajectory core: config registers and stream ports
// depends on jcrt_pkg, jcrt_front, jcrt_queue, jcrt_back
// the back end works on one beat at a time: it runs the shared multiplier sequence for
// each beat while the trajectory runs and sends the target straight out once the tick
//   counter has reached total_ticks; the front end keeps taking beats while the queue has room
// reset: clears the tick counter, the start-position valid bits and all handshakes and
//   loads the register defaults; no clearing pass, unlatched joints read start zero
module joint_cubic_return_trajectory_core #(
    parameter int MAX_JOINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // joint_index[3:0], measured_pos[35:4], target_pos[67:36], zero pad[71:68]
    input  logic [71:0] s_tdata,
    // period_start[0], restart[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_joint_index[3:0], desired_pos[35:4], desired_vel[67:36], zero pad[71:68]
    output logic [71:0] m_tdata
);
    import jcrt_pkg::*;

    jcrt_cfg_t          cfg_reg;
    logic               cfg_write;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    jcrt_item_t         push_item;
    jcrt_item_t         pop_item;
    logic [3:0]         m_joint;
    logic signed [31:0] m_pos;
    logic signed [31:0] m_vel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.total_ticks     <= TOTAL_TICKS_RST;
            cfg_reg.inv_total_ticks <= INV_TOTAL_TICKS_RST;
            cfg_reg.inv_total_time  <= INV_TOTAL_TIME_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_TOTAL_TICKS:     cfg_reg.total_ticks     <= pwdata[15:0];
                REG_INV_TOTAL_TICKS: cfg_reg.inv_total_ticks <= pwdata;
                REG_INV_TOTAL_TIME:  cfg_reg.inv_total_time  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOTAL_TICKS:     prdata = {16'd0, cfg_reg.total_ticks};
            REG_INV_TOTAL_TICKS: prdata = cfg_reg.inv_total_ticks;
            REG_INV_TOTAL_TIME:  prdata = cfg_reg.inv_total_time;
            default:             prdata = '0;
        endcase
    end

    jcrt_front #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_joint   (s_tdata[3:0]),
        .s_pstart  (s_tuser[0]),
        .s_restart (s_tuser[1]),
        .s_meas    (s_tdata[35:4]),
        .s_target  (s_tdata[67:36]),
        .q_push    (q_push),
        .q_item    (push_item),
        .q_full    (q_full)
    );

    jcrt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    jcrt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_item  (pop_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_joint (m_joint),
        .m_pos   (m_pos),
        .m_vel   (m_vel)
    );

    assign m_tdata = {4'd0, m_vel, m_pos, m_joint};

endmodule

// ===== src/jcrt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module jcrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/jcrt_front.sv =====
// front end: accepts beats, latches start positions, runs the shared tick counter
// depends on jcrt_pkg and jcrt_ram
module jcrt_front #(
    parameter int MAX_JOINTS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  jcrt_pkg::jcrt_cfg_t    cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [3:0]             s_joint,
    input  logic                   s_pstart,
    input  logic                   s_restart,
    input  logic signed [31:0]     s_meas,
    input  logic signed [31:0]     s_target,
    output logic                   q_push,
    output jcrt_pkg::jcrt_item_t   q_item,
    input  logic                   q_full
);
    import jcrt_pkg::*;

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    logic                  accept;
    logic                  in_range;
    logic [AW+3:0]         joint_ext;
    logic [AW-1:0]         addr;
    logic                  vbit;
    logic [15:0]           tick_base;
    logic [15:0]           tick_next;
    logic [15:0]           tick_reg;
    logic [MAX_JOINTS-1:0] vbits_reg;
    logic [MAX_JOINTS-1:0] vbits_next;
    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    logic [3:0]            stg_joint_reg;
    logic                  stg_done_reg;
    logic [15:0]           stg_tick_reg;
    logic signed [31:0]    stg_target_reg;
    logic signed [31:0]    stg_meas_reg;
    logic                  stg_bypass_reg;
    logic                  stg_vbit_reg;
    logic [31:0]           ram_rdata;

    assign accept    = s_valid && s_ready;
    assign in_range  = 32'(s_joint) < 32'(MAX_JOINTS);
    assign joint_ext = {{AW{1'b0}}, s_joint};
    assign addr      = joint_ext[AW-1:0];
    assign vbit      = in_range && vbits_reg[addr];

    assign tick_base = s_restart ? 16'd0 : tick_reg;
    assign tick_next = (s_pstart && (tick_base < cfg.total_ticks)) ? tick_base + 16'd1
                                                                   : tick_base;

    assign q_push  = stg_valid_reg && !q_full;
    assign s_ready = !stg_valid_reg || q_push;

    always_comb begin
        vbits_next = vbits_reg;
        if (accept && s_restart && in_range) begin
            vbits_next[addr] = 1'b1;
        end
        stg_valid_next = stg_valid_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (q_push) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            vbits_reg     <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                tick_reg <= tick_next;
            end
            vbits_reg     <= vbits_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_joint_reg  <= s_joint;
            stg_done_reg   <= tick_next >= cfg.total_ticks;
            stg_tick_reg   <= tick_next;
            stg_target_reg <= s_target;
            stg_meas_reg   <= s_meas;
            stg_bypass_reg <= s_restart && in_range;
            stg_vbit_reg   <= vbit;
        end
    end

    jcrt_ram #(
        .WIDTH (32),
        .DEPTH (MAX_JOINTS),
        .AW    (AW)
    ) u_start_ram (
        .aclk  (aclk),
        .we    (accept && s_restart && in_range),
        .waddr (addr),
        .wdata (s_meas),
        .re    (accept),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        q_item.joint  = stg_joint_reg;
        q_item.done   = stg_done_reg;
        q_item.tick   = stg_tick_reg;
        q_item.target = stg_target_reg;
        if (stg_bypass_reg) begin
            q_item.start = stg_meas_reg;
        end else if (stg_vbit_reg) begin
            q_item.start = ram_rdata;
        end else begin
            q_item.start = '0;
        end
    end

endmodule

// ===== src/jcrt_queue.sv =====
// two-entry queue between the front end and the arithmetic back end
// depends on jcrt_pkg
module jcrt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  jcrt_pkg::jcrt_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output jcrt_pkg::jcrt_item_t pop_item,
    output logic                 empty
);
    import jcrt_pkg::*;

    jcrt_item_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_item = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/jcrt_back.sv =====
// back end: sequences one shared multiplier through the cubic position and velocity
// depends on jcrt_pkg
module jcrt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jcrt_pkg::jcrt_cfg_t  cfg,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  jcrt_pkg::jcrt_item_t q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_joint,
    output logic signed [31:0]   m_pos,
    output logic signed [31:0]   m_vel
);
    import jcrt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SQ    = 10'b00_0000_0010,
        ST_CUBE  = 10'b00_0000_0100,
        ST_SHAPE = 10'b00_0000_1000,
        ST_MH    = 10'b00_0001_0000,
        ST_MG    = 10'b00_0010_0000,
        ST_THI   = 10'b00_0100_0000,
        ST_TLO   = 10'b00_1000_0000,
        ST_VEL   = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               out_load;
    logic               m_valid_reg;
    logic               m_valid_next;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] mul_reg;

    logic [3:0]         joint_reg;
    logic signed [31:0] start_reg;
    logic signed [32:0] m_reg;
    logic [30:0]        s_reg;
    logic [30:0]        s2_reg;
    logic [30:0]        h_reg;
    logic [31:0]        g_reg;
    logic signed [33:0] t_reg;
    logic signed [50:0] thi_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic [3:0]         out_joint_reg;
    logic signed [31:0] out_pos_reg;
    logic signed [31:0] out_vel_reg;

    logic [30:0]        s_c;
    logic [30:0]        s2_c;
    logic [30:0]        s3_c;
    logic signed [34:0] h_wide;
    logic [30:0]        h_c;
    logic [30:0]        diff;
    logic [33:0]        g_wide;
    logic signed [36:0] mh_sh;
    logic signed [37:0] pos_sum;
    logic signed [33:0] t_c;
    logic signed [34:0] tlo_sh;
    logic signed [51:0] vel_sum;

    // phase clamp and shape terms
    assign s_c  = (mul_reg[47:2] > {15'd0, ONE_Q30}) ? ONE_Q30 : mul_reg[32:2];
    assign s2_c = mul_reg[60:30];
    assign s3_c = mul_reg[60:30];

    assign h_wide = $signed({4'd0, s2_reg}) + $signed({3'd0, s2_reg, 1'b0})
                  - $signed({3'd0, s3_c, 1'b0});
    always_comb begin
        if (h_wide < 0) begin
            h_c = '0;
        end else if (h_wide > $signed({4'd0, ONE_Q30})) begin
            h_c = ONE_Q30;
        end else begin
            h_c = h_wide[30:0];
        end
    end

    assign diff    = s_reg - s2_reg;
    assign g_wide  = {1'b0, diff, 2'b0} + {2'b0, diff, 1'b0};
    assign mh_sh   = mul_reg[66:30];
    assign pos_sum = {{6{start_reg[31]}}, start_reg} + {mh_sh[36], mh_sh};
    assign t_c     = mul_reg[63:30];
    assign tlo_sh  = mul_reg[50:16];
    assign vel_sum = {thi_reg[50], thi_reg} + {{17{tlo_sh[34]}}, tlo_sh};

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mul_a = {18'd0, q_item.tick};
                mul_b = {1'b0, cfg.inv_total_ticks};
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = q_item.done ? ST_OUT : ST_SQ;
                end
            end
            ST_SQ: begin
                mul_a      = {3'd0, s_c};
                mul_b      = {2'd0, s_c};
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                mul_a      = {3'd0, s2_c};
                mul_b      = {2'd0, s_reg};
                state_next = ST_SHAPE;
            end
            ST_SHAPE: begin
                state_next = ST_MH;
            end
            ST_MH: begin
                mul_a      = {m_reg[32], m_reg};
                mul_b      = {2'd0, h_reg};
                state_next = ST_MG;
            end
            ST_MG: begin
                mul_a      = {m_reg[32], m_reg};
                mul_b      = {1'b0, g_reg};
                state_next = ST_THI;
            end
            ST_THI: begin
                mul_a      = t_c;
                mul_b      = {17'd0, cfg.inv_total_time[31:16]};
                state_next = ST_TLO;
            end
            ST_TLO: begin
                mul_a      = t_reg;
                mul_b      = {17'd0, cfg.inv_total_time[15:0]};
                state_next = ST_VEL;
            end
            ST_VEL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE: begin
                joint_reg <= q_item.joint;
                start_reg <= q_item.start;
                m_reg     <= {q_item.target[31], q_item.target}
                           - {q_item.start[31], q_item.start};
                pos_reg   <= q_item.target;
                vel_reg   <= '0;
            end
            ST_SQ: begin
                s_reg <= s_c;
            end
            ST_CUBE: begin
                s2_reg <= s2_c;
            end
            ST_SHAPE: begin
                h_reg <= h_c;
                g_reg <= g_wide[31:0];
            end
            ST_MH: begin
            end
            ST_MG: begin
                pos_reg <= sat32({{14{pos_sum[37]}}, pos_sum});
            end
            ST_THI: begin
                t_reg <= t_c;
            end
            ST_TLO: begin
                thi_reg <= mul_reg[50:0];
            end
            ST_VEL: begin
                vel_reg <= sat32(vel_sum);
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
        if (out_load) begin
            out_joint_reg <= joint_reg;
            out_pos_reg   <= pos_reg;
            out_vel_reg   <= vel_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_joint = out_joint_reg;
    assign m_pos   = out_pos_reg;
    assign m_vel   = out_vel_reg;

endmodule
